/* design/ssph_pkg.sv */
`default_nettype none

package ssph_pkg;

  // Input item kinds
  localparam logic KIND_TIMER  = 1'b0;
  localparam logic KIND_PACKET = 1'b1;

  localparam logic [7:0] BROADCAST_ADDR    = 8'h00;
  localparam logic [7:0] OWN_ADDRESS_RESET = 8'd9;

  // Broadcast commands
  localparam logic [7:0] CMD_START  = 8'h02;
  localparam logic [7:0] CMD_STOP   = 8'h05;
  localparam logic [7:0] CMD_TEST   = 8'h08;
  localparam logic [7:0] CMD_RESET  = 8'h09;
  // Addressed commands
  localparam logic [7:0] CMD_READ   = 8'h03;
  localparam logic [7:0] CMD_RESEND = 8'h13;
  localparam logic [7:0] CMD_CONFIG = 8'h06;

  localparam logic [7:0] ACK_OK = 8'h01;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SAMPLE,
    OP_TEST,
    OP_READ,
    OP_RESEND,
    OP_ACK
  } op_t;

  typedef enum logic [1:0] {
    PUSH_HI,
    PUSH_LO,
    PUSH_TEST
  } push_sel_t;

  typedef enum logic [1:0] {
    HDR_B0,
    HDR_B1,
    HDR_B2
  } hdr_sel_t;

  typedef struct packed {
    logic      accept;
    logic      push;
    push_sel_t push_sel;
    logic      pop;
    logic      drain;
    logic      clr_pairs;
    logic      wr_hi;
    logic      wr_lo;
    logic      hdr_wr;
    hdr_sel_t  hdr_idx;
    logic      send_init;
    logic      send_rd;
    logic      send_ld;
    op_t       op;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic fill_ge2;
    logic pairs_done;
    logic out_free;
    logic send_last;
  } dp_stat_t;

endpackage

`default_nettype wire

/* design/ssph_item_if.sv */
`default_nettype none

interface ssph_item_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [11:0] sample;
  logic [7:0]  dest_address;
  logic [7:0]  command;
  logic [7:0]  new_ratio;

  modport source (output valid, kind, sample, dest_address, command, new_ratio,
                  input ready);
  modport sink (input valid, kind, sample, dest_address, command, new_ratio,
                output ready);
endinterface

`default_nettype wire

/* design/ssph_result_if.sv */
`default_nettype none

interface ssph_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last;

  modport source (output valid, tx_byte, last, input ready);
  modport sink (input valid, tx_byte, last, output ready);
endinterface

`default_nettype wire

/* design/ssph_ctrl.sv */
`default_nettype none

module ssph_ctrl
  import ssph_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_PUSH_HI = 12'b0000_0000_0010,
    S_PUSH_LO = 12'b0000_0000_0100,
    S_TEST    = 12'b0000_0000_1000,
    S_RD_CHK  = 12'b0000_0001_0000,
    S_RD_HI   = 12'b0000_0010_0000,
    S_RD_LO   = 12'b0000_0100_0000,
    S_HDR0    = 12'b0000_1000_0000,
    S_HDR1    = 12'b0001_0000_0000,
    S_HDR2    = 12'b0010_0000_0000,
    S_SEND_RD = 12'b0100_0000_0000,
    S_SEND_LD = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;
  op_t    op_q, op_q_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.op     = op_q;
    state_next = state;
    op_q_next  = op_q;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          cmd.op     = stat.op;
          op_q_next  = stat.op;
          unique case (stat.op)
            OP_SAMPLE: state_next = S_PUSH_HI;
            OP_TEST:   state_next = S_TEST;
            OP_READ: begin
              cmd.clr_pairs = 1'b1;
              state_next    = S_RD_CHK;
            end
            OP_RESEND: begin
              cmd.send_init = 1'b1;
              state_next    = S_SEND_RD;
            end
            OP_ACK:    state_next = S_HDR0;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_PUSH_HI: begin
        cmd.push     = 1'b1;
        cmd.push_sel = PUSH_HI;
        state_next   = S_PUSH_LO;
      end
      S_PUSH_LO: begin
        cmd.push     = 1'b1;
        cmd.push_sel = PUSH_LO;
        state_next   = S_IDLE;
      end
      S_TEST: begin
        cmd.push     = 1'b1;
        cmd.push_sel = PUSH_TEST;
        state_next   = S_HDR0;
      end
      S_RD_CHK: begin
        // stop on a full packet, drop a short tail and close the packet, or pop a pair
        priority if (stat.pairs_done) begin
          state_next = S_HDR0;
        end else if (!stat.fill_ge2) begin
          cmd.drain  = 1'b1;
          state_next = S_HDR0;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_RD_HI;
        end
      end
      S_RD_HI: begin
        cmd.wr_hi  = 1'b1;
        cmd.pop    = 1'b1;
        state_next = S_RD_LO;
      end
      S_RD_LO: begin
        cmd.wr_lo  = 1'b1;
        state_next = S_RD_CHK;
      end
      S_HDR0: begin
        cmd.hdr_wr  = 1'b1;
        cmd.hdr_idx = HDR_B0;
        state_next  = S_HDR1;
      end
      S_HDR1: begin
        cmd.hdr_wr  = 1'b1;
        cmd.hdr_idx = HDR_B1;
        state_next  = S_HDR2;
      end
      S_HDR2: begin
        cmd.hdr_wr    = 1'b1;
        cmd.hdr_idx   = HDR_B2;
        cmd.send_init = 1'b1;
        state_next    = S_SEND_RD;
      end
      S_SEND_RD: begin
        cmd.send_rd = 1'b1;
        state_next  = S_SEND_LD;
      end
      S_SEND_LD: begin
        if (stat.out_free) begin
          cmd.send_ld = 1'b1;
          state_next  = stat.send_last ? S_IDLE : S_SEND_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op_q  <= OP_NONE;
    end else begin
      state <= state_next;
      op_q  <= op_q_next;
    end
  end

endmodule

`default_nettype wire

/* design/ssph_dp.sv */
`default_nettype none

module ssph_dp
  import ssph_pkg::*;
#(
  parameter int FIFO_DEPTH         = 120,
  parameter int SAMPLES_PER_PACKET = 13
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        item_kind,
  input  logic [11:0] item_sample,
  input  logic [7:0]  item_dest_address,
  input  logic [7:0]  item_command,
  input  logic [7:0]  item_new_ratio,
  input  logic        result_ready,
  output logic        result_valid,
  output logic [7:0]  result_tx_byte,
  output logic        result_last,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat
);

  localparam int PAIR_BYTES = 2 * SAMPLES_PER_PACKET;
  localparam int PKT_MAX    = PAIR_BYTES + 3;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);
  localparam int PA_W       = $clog2(PKT_MAX);
  localparam int PL_W       = $clog2(PKT_MAX + 1);
  localparam int CNT_W      = $clog2(PAIR_BYTES + 1);

  logic [7:0]        own_address;
  logic              acquiring;
  logic [7:0]        prescale_count;
  logic [7:0]        overflow_ratio;
  logic [7:0]        test_counter;
  logic [PTR_W-1:0]  write_pos;
  logic [PTR_W-1:0]  read_pos;
  logic [FILL_W-1:0] fill_count;
  logic [CNT_W-1:0]  pair_bytes;
  logic [PL_W-1:0]   packet_length;
  logic [PA_W-1:0]   send_idx;
  logic [PL_W-1:0]   send_len;
  logic [11:0]       sample_q;

  logic [7:0] sample_store [FIFO_DEPTH];
  logic [7:0] packet_store [PKT_MAX];
  logic [7:0] fifo_rdata;
  logic [7:0] pkt_rdata;

  logic       is_bcast;
  logic       is_addressed;
  logic       take;
  logic [7:0] push_data;
  logic [7:0] fill_byte;
  logic [7:0] hdr_data;
  logic [PA_W-1:0] pkt_wr_addr;
  logic [7:0]      pkt_wr_data;
  logic            pkt_wr_en;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Decode the item on the input channel
  assign is_bcast     = (item_dest_address == BROADCAST_ADDR);
  assign is_addressed = (item_dest_address == own_address);
  assign take         = acquiring && ((overflow_ratio == '0) || (prescale_count == '0));

  always_comb begin
    stat.op         = OP_NONE;
    stat.fill_ge2   = (fill_count >= FILL_W'(2));
    stat.pairs_done = (pair_bytes == CNT_W'(PAIR_BYTES));
    stat.out_free   = !result_valid || result_ready;
    stat.send_last  = ((PL_W'(send_idx) + PL_W'(1)) == send_len);
    priority if (item_kind == KIND_TIMER) begin
      stat.op = take ? OP_SAMPLE : OP_NONE;
    end else if (is_bcast && (item_command == CMD_TEST)) begin
      stat.op = OP_TEST;
    end else if (is_addressed && (item_command == CMD_READ)) begin
      stat.op = OP_READ;
    end else if (is_addressed && (item_command == CMD_RESEND) && (packet_length != '0)) begin
      stat.op = OP_RESEND;
    end else if (is_addressed && (item_command == CMD_CONFIG)) begin
      stat.op = OP_ACK;
    end else begin
      stat.op = OP_NONE;
    end
  end

  always_comb begin
    unique case (cmd.push_sel)
      PUSH_HI:   push_data = {4'h0, sample_q[11:8]};
      PUSH_LO:   push_data = sample_q[7:0];
      PUSH_TEST: push_data = test_counter;
      default:   push_data = test_counter;
    endcase
  end

  assign fill_byte = 8'(fill_count);

  always_comb begin
    hdr_data = own_address;
    unique case (cmd.hdr_idx)
      HDR_B0: hdr_data = own_address;
      HDR_B1: begin
        unique case (cmd.op)
          OP_READ: hdr_data = {4'h0, fill_byte[6:3]};
          OP_TEST: hdr_data = fill_byte;
          default: hdr_data = CMD_CONFIG;
        endcase
      end
      HDR_B2: begin
        unique case (cmd.op)
          OP_READ: hdr_data = 8'(pair_bytes);
          OP_TEST: hdr_data = test_counter;
          default: hdr_data = ACK_OK;
        endcase
      end
      default: hdr_data = own_address;
    endcase
  end

  always_comb begin
    pkt_wr_en   = cmd.wr_hi || cmd.wr_lo || cmd.hdr_wr;
    pkt_wr_addr = PA_W'(cmd.hdr_idx);
    pkt_wr_data = hdr_data;
    priority if (cmd.wr_hi) begin
      pkt_wr_addr = PA_W'(pair_bytes) + PA_W'(3);
      pkt_wr_data = fifo_rdata;
    end else if (cmd.wr_lo) begin
      pkt_wr_addr = PA_W'(pair_bytes) + PA_W'(4);
      pkt_wr_data = fifo_rdata;
    end else begin
      pkt_wr_addr = PA_W'(cmd.hdr_idx);
      pkt_wr_data = hdr_data;
    end
  end

  // Memories
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      sample_store[write_pos] <= push_data;
    end
    if (cmd.pop) begin
      fifo_rdata <= sample_store[read_pos];
    end
    if (pkt_wr_en) begin
      packet_store[pkt_wr_addr] <= pkt_wr_data;
    end
    if (cmd.send_rd) begin
      pkt_rdata <= packet_store[send_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_q <= item_sample;
    end
    if (cmd.send_ld) begin
      result_tx_byte <= pkt_rdata;
      result_last    <= stat.send_last;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address    <= OWN_ADDRESS_RESET;
      acquiring      <= 1'b0;
      prescale_count <= '0;
      overflow_ratio <= '0;
      test_counter   <= '0;
      write_pos      <= '0;
      read_pos       <= '0;
      fill_count     <= '0;
      pair_bytes     <= '0;
      packet_length  <= '0;
      send_idx       <= '0;
      send_len       <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        own_address <= cfg_wr_data;
      end

      if (cmd.accept) begin
        if (item_kind == KIND_TIMER) begin
          if (acquiring && (overflow_ratio != '0)) begin
            prescale_count <= (prescale_count == '0) ? overflow_ratio
                                                     : prescale_count - 8'd1;
          end
        end else begin
          if (is_bcast) begin
            unique case (item_command)
              CMD_START: acquiring <= 1'b1;
              CMD_STOP:  acquiring <= 1'b0;
              CMD_RESET: begin
                acquiring  <= 1'b0;
                write_pos  <= '0;
                read_pos   <= '0;
                fill_count <= '0;
              end
              default: ;
            endcase
          end
          if (is_addressed && (item_command == CMD_CONFIG)) begin
            overflow_ratio <= item_new_ratio;
          end
        end
      end

      // FIFO pointers; push, pop and drain never coincide
      priority if (cmd.push) begin
        write_pos <= ptr_inc(write_pos);
        if (fill_count == FILL_W'(FIFO_DEPTH)) begin
          read_pos <= ptr_inc(read_pos);
        end else begin
          fill_count <= fill_count + FILL_W'(1);
        end
      end else if (cmd.pop) begin
        read_pos   <= ptr_inc(read_pos);
        fill_count <= fill_count - FILL_W'(1);
      end else if (cmd.drain) begin
        if (fill_count != '0) begin
          read_pos <= ptr_inc(read_pos);
        end
        fill_count <= '0;
      end

      if (cmd.clr_pairs) begin
        pair_bytes <= '0;
      end else if (cmd.wr_lo) begin
        pair_bytes <= pair_bytes + CNT_W'(2);
      end

      if (cmd.hdr_wr && (cmd.hdr_idx == HDR_B2)) begin
        if (cmd.op == OP_READ) begin
          packet_length <= PL_W'(pair_bytes) + PL_W'(3);
        end
        if (cmd.op == OP_TEST) begin
          test_counter <= test_counter + 8'd1;
        end
      end

      if (cmd.send_init) begin
        send_idx <= '0;
        unique case (cmd.op)
          OP_READ:   send_len <= PL_W'(pair_bytes) + PL_W'(3);
          OP_RESEND: send_len <= packet_length;
          default:   send_len <= PL_W'(3);
        endcase
      end else if (cmd.send_ld) begin
        send_idx <= send_idx + PA_W'(1);
      end

      if (cmd.send_ld) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* design/sensor_sample_packet_handler.sv */
`default_nettype none

// Sensor sample packet handler. Timer items carry one 12-bit ADC sample; while
// acquiring, the overflow-ratio prescaler picks which samples enter a byte FIFO
// of FIFO_DEPTH entries as a high nibble then a low byte, overwriting the
// oldest byte when full. Radio packet items carry broadcast commands (start,
// stop, test push, FIFO reset) or commands addressed to own_address (read up
// to SAMPLES_PER_PACKET samples, re-send the stored packet at the last read's
// length, set the ratio and acknowledge). Each transmitted packet leaves as one
// result request per byte, with last set on the final byte. One item is worked
// on at a time: the input is ready only while the controller idles. An item
// that neither pushes nor replies is done once accepted (start, stop, reset, a
// timer item ignored or skipped by the prescaler, an unknown command, another
// destination, a re-send with nothing stored). A pushing timer item writes the
// high then the low byte to the FIFO; a test push writes its byte, an
// acknowledge nothing, and a read each sample pair in turn, before the three
// header bytes. Then each packet byte (29 for a full read with the defaults) is
// read from the packet memory and loaded into the output register; a re-send
// starts here. The sample FIFO memory and the packet memory each have a single
// read port; stalls on the result channel hold the send. The output register
// lets the next item be accepted while the last byte still waits. own_address
// may be written only while the block is idle. No memory clearing pass runs
// after reset.

module sensor_sample_packet_handler
  import ssph_pkg::*;
#(
  parameter int FIFO_DEPTH         = 120,
  parameter int SAMPLES_PER_PACKET = 13
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  ssph_item_if.sink   item,
  ssph_result_if.source result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     item_ready;

  assign item.ready = item_ready;

  // Sequence each request: dispatch on the decoded op, FIFO moves, header writes, byte send
  ssph_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Hold the FIFO, packet store, prescaler and output register
  ssph_dp #(
    .FIFO_DEPTH         (FIFO_DEPTH),
    .SAMPLES_PER_PACKET (SAMPLES_PER_PACKET)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .item_kind         (item.kind),
    .item_sample       (item.sample),
    .item_dest_address (item.dest_address),
    .item_command      (item.command),
    .item_new_ratio    (item.new_ratio),
    .result_ready      (result.ready),
    .result_valid      (result.valid),
    .result_tx_byte    (result.tx_byte),
    .result_last       (result.last),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule

`default_nettype wire

/* design/ssph_checker.sv */
`default_nettype none

module ssph_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] result_tx_byte,
  input logic       result_last
);

  // A stalled result request holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(result_tx_byte) && $stable(result_last))
    else $error("result changed while stalled");

  // No new item is taken while a packet is still being sent
  a_no_accept_mid_packet: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_last |-> !item_ready)
    else $error("input ready in the middle of a packet");

  // Reset leaves the block idle with no pending result
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid && item_ready)
    else $error("block not idle after reset");

endmodule

bind sensor_sample_packet_handler ssph_checker u_ssph_checker (
  .clk            (clk),
  .rst            (rst),
  .item_ready     (item.ready),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .result_tx_byte (result.tx_byte),
  .result_last    (result.last)
);

`default_nettype wire
